/* rtl/core/frpj_pkg.sv */
// Package for the forest root finder: request and response structs,
// command codes and field widths. No dependencies.
`default_nettype none

package frpj_pkg;

	localparam int NODE_W = 10;
	localparam int PASS_W = 11;

	// Saturation value of the reported pass count
	localparam logic [PASS_W-1:0] PASS_MAX = 11'h7FF;

	// Request command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [NODE_W-1:0] node_value;
		logic              last_node;
	} req_t;

	typedef struct packed {
		logic [NODE_W-1:0] root_index;
		logic [PASS_W-1:0] pass_count;
		logic              query_valid;
	} rsp_t;

endpackage

`default_nettype wire

/* rtl/core/forest_root_pointer_jumping.sv */
// Forest root finder by pointer jumping over a parent table in one RAM.
// Depends on frpj_pkg.
//
// Usage: requests arrive on req (valid/stall). A load request (cmd = load)
// writes the next parent entry; the load flagged last_node closes the table
// and starts resolution. A load after a finished resolution starts a new table.
// A query request returns one response on rsp (valid/stall) with the root of
// the node, the pass count and a valid flag; loads return nothing.
// A load is taken while idle. A query's response is registered in S_QUERY once
// the output register is empty or not stalled; req_stall is held until then, so
// a new query is not taken before the last one's response is registered.
// Resolution runs through the single read port of the parent RAM: each pass
// starts in S_START, then visits each node in S_NODE, and a node whose parent
// is in range also goes through S_GRAND; it runs until a pass changes nothing (at most
// MAX_NODES + 1 passes). req_stall is high while a query or resolution is in
// progress. A finished response is held in an output register while rsp_stall
// is high; new loads are still taken meanwhile, a new query waits for the slot.
// Reset clears the control state, the entry count and the resolved flag; the
// parent RAM is not cleared; a query may read an unloaded entry but ignores it.

`default_nettype none

module forest_root_pointer_jumping #(
	parameter int MAX_NODES = 1024
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire frpj_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output frpj_pkg::rsp_t      rsp
);
	import frpj_pkg::*;

	localparam int AW   = $clog2(MAX_NODES);
	localparam int CW   = $clog2(MAX_NODES + 1);
	localparam int PCW  = $clog2(MAX_NODES + 2);
	localparam int PW   = (PCW > PASS_W) ? PCW : PASS_W;
	localparam int CMPW = (CW > NODE_W) ? CW : NODE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_NODE,
		S_GRAND,
		S_QUERY
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic              resolved_q;
	logic [PCW-1:0]    pass_q;
	logic [AW-1:0]     i_q;
	logic              changed_q;
	logic [NODE_W-1:0] p_q;
	logic [NODE_W-1:0] q_val_q;
	logic              q_ok_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [NODE_W-1:0] parent_mem_q [MAX_NODES];
	logic [NODE_W-1:0] rd_q;

	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [NODE_W-1:0] mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;

	logic [CW-1:0]     cnt_eff;
	logic              load_room;
	logic              query_ok;
	logic [NODE_W-1:0] g_val;
	logic              rd_in_range;
	logic              adv;
	logic              chg;
	logic              last_idx;
	logic [PCW-1:0]    pass_nx;
	logic              more;
	logic              rsp_load;
	logic [PW-1:0]     pass_w;
	logic [PASS_W-1:0] pass_sat;
	logic [NODE_W-1:0] q_root;

	// Parent value below the entry count, i.e. a real parent
	function automatic logic lt_cnt(input logic [NODE_W-1:0] v, input logic [CW-1:0] c);
		lt_cnt = CMPW'(v) < CMPW'(c);
	endfunction

	// Parent table RAM, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			parent_mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= parent_mem_q[mem_ra];
		end
	end

	// Sequencer datapath and RAM port control
	always_comb begin
		cnt_eff     = resolved_q ? '0 : count_q;
		load_room   = cnt_eff < CW'(MAX_NODES);
		query_ok    = resolved_q && lt_cnt(req.node_value, count_q);
		rd_in_range = lt_cnt(rd_q, count_q);
		g_val       = rd_in_range ? rd_q : p_q;
		last_idx    = (CW'(i_q) + CW'(1)) == count_q;
		pass_w      = PW'(pass_q);
		pass_sat    = (pass_w > PW'(PASS_MAX)) ? PASS_MAX : pass_w[PASS_W-1:0];
		q_root      = (q_ok_q && rd_in_range) ? rd_q : q_val_q;
		mem_we      = 1'b0;
		mem_wa      = i_q;
		mem_wd      = g_val;
		mem_re      = 1'b0;
		mem_ra      = i_q;
		adv         = 1'b0;
		chg         = changed_q;
		rsp_load    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid && req.cmd == CMD_LOAD && load_room) begin
					mem_we = 1'b1;
					mem_wa = AW'(cnt_eff);
					mem_wd = req.node_value;
				end
				if (req_valid && req.cmd == CMD_QUERY) begin
					mem_re = 1'b1;
					mem_ra = AW'(req.node_value);
				end
			end
			S_START: begin
				mem_re = 1'b1;
			end
			S_NODE: begin
				// in-range parent: read the grandparent; out-of-range parent: nothing to jump
				if (rd_in_range) begin
					mem_re = 1'b1;
					mem_ra = AW'(rd_q);
				end else begin
					adv = 1'b1;
				end
			end
			S_GRAND: begin
				adv = 1'b1;
				if (g_val != p_q) begin
					mem_we = 1'b1;
					chg    = 1'b1;
				end
			end
			S_QUERY: begin
				rsp_load = !rsp_valid_q || !rsp_stall;
			end
			default: begin
			end
		endcase
		// Prefetch the next node of the pass
		if (adv && !last_idx) begin
			mem_re = 1'b1;
			mem_ra = i_q + AW'(1);
		end
		pass_nx = pass_q + PCW'(1);
		more    = chg && (pass_nx != PCW'(MAX_NODES + 1));
	end

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			resolved_q  <= 1'b0;
			pass_q      <= '0;
			i_q         <= '0;
			changed_q   <= 1'b0;
			p_q         <= '0;
			q_val_q     <= '0;
			q_ok_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid && req.cmd == CMD_LOAD) begin
						resolved_q <= 1'b0;
						count_q    <= load_room ? cnt_eff + CW'(1) : cnt_eff;
						if (resolved_q) begin
							pass_q <= '0;
						end
						if (req.last_node) begin
							i_q       <= '0;
							changed_q <= 1'b0;
							pass_q    <= '0;
							state_q   <= S_START;
						end
					end else if (req_valid) begin
						q_val_q <= req.node_value;
						q_ok_q  <= query_ok;
						state_q <= S_QUERY;
					end
				end
				S_START: begin
					state_q <= S_NODE;
				end
				S_NODE: begin
					if (!adv) begin
						p_q     <= rd_q;
						state_q <= S_GRAND;
					end
				end
				S_GRAND: begin
				end
				S_QUERY: begin
					if (rsp_load) begin
						rsp_q.root_index  <= q_root;
						rsp_q.pass_count  <= q_ok_q ? pass_sat : '0;
						rsp_q.query_valid <= q_ok_q;
						rsp_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// Step to the next node, next pass, or finish
			if (adv) begin
				changed_q <= chg;
				if (!last_idx) begin
					i_q     <= i_q + AW'(1);
					state_q <= S_NODE;
				end else if (more) begin
					pass_q    <= pass_nx;
					i_q       <= '0;
					changed_q <= 1'b0;
					state_q   <= S_START;
				end else begin
					pass_q     <= pass_nx;
					resolved_q <= 1'b1;
					state_q    <= S_IDLE;
				end
			end
		end
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	// Entry count never exceeds the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_NODES))
		else $error("entry count beyond table depth");

	// A jump only follows an in-range parent
	a_parent_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GRAND |-> lt_cnt(p_q, count_q))
		else $error("jump through out-of-range parent");

	// A finished resolution has counted at least one pass
	a_pass_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(resolved_q) |-> pass_q != '0)
		else $error("resolution finished with zero passes");

	// RAM writes happen only on a load or a grandparent update
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_GRAND || (state_q == S_IDLE && req_valid)))
		else $error("unexpected parent table write");
`endif

endmodule

`default_nettype wire
